[hw/rtl/cfq_pkg.sv]
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and constants of the circular FIFO queue
// Sizes of the entry store, stream beat layouts, status codes and index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

	// storage geometry
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int CAP_W  = 5;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// stream beat widths, padded to whole bytes
	localparam int IN_TW   = ((DATA_W + 7) / 8) * 8;
	localparam int OUT_RAW = STAT_W + 3 * DATA_W + OCC_W;
	localparam int OUT_TW  = ((OUT_RAW + 7) / 8) * 8;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// operation kinds carried in tuser
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// map a written capacity into 1..DEPTH
	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (32'(v) > DEPTH)
			r = CNT_W'(DEPTH);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	// step an index by one, wrapping at the capacity
	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] n;
		logic [IDX_W-1:0] r;
		n = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
		if (n >= (CNT_W+1)'(cap))
			r = '0;
		else
			r = IDX_W'(n);
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/cfq_ram.sv]
// ----------------------------------------------------------------------------
// cfq_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/circular_fifo_queue.sv]
// ----------------------------------------------------------------------------
// circular_fifo_queue: ring-buffer FIFO with run-time capacity
// Enqueue/dequeue beats in, one status beat out per operation.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_axis    | in  | tuser: kind (0 enq, 1 deq); tdata: push_value
//  m_axis    | out | tdata: status, popped, head, tail, occupancy
//  cfg       | in  | capacity write, taken only while empty
//
//  An operation updates indices and the entry store at its accept edge; a
//  dequeue reads the next head entry from the RAM, which returns in the next
//  cycle and is forwarded into the result. Results leave from a status stage
//  and an output register, so one beat per cycle is taken while the output
//  is drained; a stalled output holds the input off after two beats queue up.
//  Reset empties the queue and sets capacity 16; the entry store keeps no
//  reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue
	import cfq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_TW-1:0]  s_axis_tdata,  // push_value
	input  wire logic [0:0]        s_axis_tuser,  // kind
	// master stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [OUT_TW-1:0] m_axis_tdata,  // status, popped_value, head_value,
	                                               // tail_value, occupancy, zero pad
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata      // capacity
);

	// queue state
	logic [CNT_W-1:0]  cap_q;
	logic [IDX_W-1:0]  head_idx_q, tail_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] head_val_q, tail_val_q;
	logic              rd_pend_q;

	// status stage and output register
	logic              s1_valid_q;
	status_t           s1_status_s1;
	logic [DATA_W-1:0] s1_popped_s1;
	logic              out_valid_q;
	logic [OUT_TW-1:0] out_data_q;

	logic              out_free, in_acc, is_deq, full, empty, enq_ok, deq_ok, cap_wr;
	logic [DATA_W-1:0] push, head_cur, ram_rdata, head_out, tail_out;
	logic [IDX_W-1:0]  head_nx, tail_nx;
	logic [CNT_W-1:0]  cap_new;
	status_t           status_in;

	// handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// decode of the incoming beat
	assign is_deq  = (s_axis_tuser[0] == KIND_DEQ);
	assign push    = s_axis_tdata[DATA_W-1:0];
	assign full    = (count_q >= cap_q);
	assign empty   = (count_q == '0);
	assign enq_ok  = in_acc && !is_deq && !full;
	assign deq_ok  = in_acc && is_deq && !empty;
	assign head_nx = advance(head_idx_q, cap_q);
	assign tail_nx = advance(tail_idx_q, cap_q);
	assign cap_new = clamp_cap(cfg_wdata);
	assign cap_wr  = cfg_we && empty;

	// head entry forwarded from the ram the cycle after a dequeue
	assign head_cur = rd_pend_q ? ram_rdata : head_val_q;

	always_comb begin
		if (is_deq)
			status_in = empty ? ST_EMPTY : ST_OK;
		else
			status_in = full ? ST_FULL : ST_OK;
	end

	cfq_ram #(
		.DATA_W (DATA_W),
		.DEPTH  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (enq_ok),
		.waddr (tail_nx),
		.wdata (push),
		.re    (deq_ok),
		.raddr (head_nx),
		.rdata (ram_rdata)
	);

	// indices, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= clamp_cap(CAP_RESET);
			head_idx_q <= '0;
			tail_idx_q <= IDX_W'(clamp_cap(CAP_RESET) - CNT_W'(1));
			count_q    <= '0;
			rd_pend_q  <= 1'b0;
		end else begin
			rd_pend_q <= deq_ok;
			if (cap_wr) begin
				cap_q      <= cap_new;
				head_idx_q <= '0;
				tail_idx_q <= IDX_W'(cap_new - CNT_W'(1));
			end else if (enq_ok) begin
				tail_idx_q <= tail_nx;
				count_q    <= count_q + CNT_W'(1);
			end else if (deq_ok) begin
				head_idx_q <= head_nx;
				count_q    <= count_q - CNT_W'(1);
			end
		end
	end

	// cached head and tail entries
	always_ff @(posedge clk) begin
		if (enq_ok) begin
			tail_val_q <= push;
			head_val_q <= empty ? push : head_cur;
		end else begin
			head_val_q <= head_cur;
		end
	end

	// status stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_axis_tready)
			s1_valid_q <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_status_s1 <= status_in;
			s1_popped_s1 <= deq_ok ? head_cur : '0;
		end
	end

	// result fields from the state left by the item in the status stage
	assign head_out = empty ? '0 : head_cur;
	assign tail_out = empty ? '0 : tail_val_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && out_free)
			out_data_q <= OUT_TW'({OCC_W'(count_q), tail_out, head_out,
				s1_popped_s1, s1_status_s1});
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above capacity");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (s1_valid_q && out_valid_q))
		else $error("input held off with a free result slot");

	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(in_acc && is_deq))
		else $error("head read pending without a dequeue");

	a_cap_reset: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && empty |=> (head_idx_q == '0) && (count_q == '0))
		else $error("capacity write did not reset the head index");

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream-level check of the circular FIFO queue
// Drives enqueue/dequeue beats and capacity writes, predicts every status beat
// with a ring-buffer model held in a scoreboard, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import cfq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam int NUM_PHASES  = 12;

	// one predicted status beat
	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] popped;
		logic [DATA_W-1:0] head_v;
		logic [DATA_W-1:0] tail_v;
		logic [OCC_W-1:0]  occ;
	} queue_result_t;

	// ring-buffer predictor plus the queue of awaited status beats
	class fifo_scoreboard;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned       head_idx;
		int unsigned       tail_idx;
		int unsigned       held;
		int unsigned       cap;
		queue_result_t     awaited [$];
		int unsigned       errors;

		function new();
			foreach (slots[i])
				slots[i] = '0;
			cap      = DEPTH;
			head_idx = 0;
			tail_idx = cap - 1;
			held     = 0;
			errors   = 0;
		endfunction

		function int unsigned wrap_next(int unsigned i);
			return (i + 1 >= cap) ? 0 : i + 1;
		endfunction

		// capacity write, ignored unless the queue is empty
		function void set_capacity(logic [CAP_W-1:0] v);
			if (held != 0)
				return;
			if (v == '0)
				cap = 1;
			else if (int'(v) > DEPTH)
				cap = DEPTH;
			else
				cap = v;
			head_idx = 0;
			tail_idx = cap - 1;
		endfunction

		// accepted operation beat: update the ring and queue the expected status
		function void note_input(logic kind, logic [DATA_W-1:0] v);
			queue_result_t r;
			r.status = ST_OK;
			r.popped = '0;
			if (kind == KIND_ENQ) begin
				if (held >= cap) begin
					r.status = ST_FULL;
				end else begin
					tail_idx = wrap_next(tail_idx);
					slots[tail_idx] = v;
					held++;
				end
			end else begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = slots[head_idx];
					head_idx = wrap_next(head_idx);
					held--;
				end
			end
			r.head_v = (held != 0) ? slots[head_idx] : '0;
			r.tail_v = (held != 0) ? slots[tail_idx] : '0;
			r.occ    = OCC_W'(held);
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] exp_v,
				logic [DATA_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// accepted status beat: compare with the oldest prediction
		function void check_result(logic [OUT_TW-1:0] beat);
			queue_result_t r;
			if (awaited.size() == 0) begin
				$error("status beat with nothing awaited: 0x%0h", beat);
				errors++;
				return;
			end
			r = awaited.pop_front();
			compare_field("status", DATA_W'(r.status), DATA_W'(beat[STAT_W-1:0]));
			compare_field("popped_value", r.popped, beat[STAT_W +: DATA_W]);
			compare_field("head_value", r.head_v, beat[STAT_W+DATA_W +: DATA_W]);
			compare_field("tail_value", r.tail_v, beat[STAT_W+2*DATA_W +: DATA_W]);
			compare_field("occupancy", DATA_W'(r.occ), DATA_W'(beat[STAT_W+3*DATA_W +: OCC_W]));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_TW-1:0]  s_axis_tdata = '0;   // push_value
	logic [0:0]        s_axis_tuser = '0;   // kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_TW-1:0] m_axis_tdata;        // status, popped_value, head_value,
	                                        // tail_value, occupancy
	logic              cfg_we = 1'b0;
	logic [CAP_W-1:0]  cfg_wdata = '0;      // capacity

	fifo_scoreboard sb = new();

	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_token = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	circular_fifo_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	always #10 clk = ~clk;

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = 300;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// one operation beat, called and returning at a falling edge
	task automatic send_op(logic kind, logic [DATA_W-1:0] v);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= IN_TW'(v);
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(kind, v);
		@(negedge clk);
	endtask

	// stop offering and wait until every status beat is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_capacity(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// idle pattern, changed away from the falling edge the receiver uses
	task automatic set_mode(int unsigned mode);
		@(posedge clk);
		case (mode)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
			default: begin src_idle_pct = 14; snk_stall_pct = 14; end
		endcase
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return DATA_W'($urandom);
	endfunction

	initial begin
		logic [CAP_W-1:0] caps [NUM_PHASES];
		int unsigned      enq_pct [NUM_PHASES];
		int unsigned      n_items;

		caps    = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd2, 5'd20, 5'd16, 5'd8, 5'd3,
			5'd15, 5'd16};
		enq_pct = '{60, 50, 55, 50, 65, 40, 70, 50, 60, 35, 75, 55};

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// directed: empty refusal, extreme values, wrap at capacity one and three
		send_op(KIND_DEQ, 32'h0000_0000);
		send_op(KIND_ENQ, 32'h0000_0000);
		send_op(KIND_ENQ, 32'hFFFF_FFFF);
		send_op(KIND_DEQ, 32'hFFFF_FFFF);
		send_op(KIND_DEQ, 32'h0000_0000);
		send_op(KIND_DEQ, 32'h0000_0000);
		wait_drained();
		// zero capacity is taken as one
		write_capacity(5'd0);
		send_op(KIND_ENQ, 32'h1234_5678);
		send_op(KIND_ENQ, 32'hDEAD_BEEF);
		send_op(KIND_DEQ, 32'h0000_0000);
		send_op(KIND_DEQ, 32'h0000_0000);
		wait_drained();
		write_capacity(5'd3);
		send_op(KIND_ENQ, 32'hA5A5_A5A5);
		send_op(KIND_ENQ, 32'h5A5A_5A5A);
		send_op(KIND_ENQ, 32'h8000_0001);
		send_op(KIND_ENQ, 32'h7FFF_FFFE);
		send_op(KIND_DEQ, 32'h0000_0000);
		wait_drained();
		// capacity write while entries are held is ignored
		write_capacity(5'd31);
		send_op(KIND_ENQ, 32'h0F0F_0F0F);
		send_op(KIND_DEQ, 32'h0000_0000);
		send_op(KIND_DEQ, 32'h0000_0000);
		send_op(KIND_DEQ, 32'h0000_0000);
		wait_drained();
		// oversize capacity is clamped to the store depth
		write_capacity(5'd31);

		// random phases over capacities and idle patterns
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_capacity(caps[p]);
			set_mode(p % 4);
			if (p == 7) begin
				@(posedge clk);
				hold_token++;
				@(negedge clk);
			end
			n_items = 80 + $urandom_range(10);
			for (int i = 0; i < n_items; i++)
				send_op(($urandom_range(99) < enq_pct[p]) ? KIND_ENQ : KIND_DEQ,
					pick_value());
			// empty the queue so the next capacity write takes effect
			while (sb.held != 0)
				send_op(KIND_DEQ, pick_value());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire
